// File: rtl/core/crr_pkg.sv
`default_nettype none

package crr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_FRAC_BITS = 24;
  localparam int MAX_RUN         = 64;

  localparam int PHASE_BITS = 32;
  localparam int NUM_CH     = 2;
  localparam int NUM_HIST   = 3;
  // Horner accumulator: coefficients grow by up to 12x the sample range
  localparam int H_BITS     = SAMPLE_BITS + 6;
  localparam int PROD_BITS  = H_BITS + PHASE_FRAC_BITS + 1;
  localparam int RUN_BITS   = $clog2(MAX_RUN + 1);

  localparam int SMAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SMIN = -SMAX - 1;

  localparam logic [PHASE_BITS-1:0] PH_ONE    = PHASE_BITS'(64'd1 << PHASE_FRAC_BITS);
  localparam logic [PHASE_BITS-1:0] PH_RESET  = PHASE_BITS'(64'd2 << PHASE_FRAC_BITS);
  localparam logic [PHASE_BITS-1:0] RATIO_MIN = PHASE_BITS'(64'd1 << (PHASE_FRAC_BITS - 6));
  localparam logic [PHASE_BITS-1:0] RATIO_MAX = PHASE_BITS'(64'd200 << PHASE_FRAC_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_EMIT
  } crr_state_t;

  // Horner pass: which coefficient is added after the multiply
  typedef enum logic [1:0] {
    HS_C2,
    HS_C1,
    HS_C0
  } crr_hstep_t;

  typedef struct packed {
    logic       load;
    logic       h_init;
    logic       h_step;
    crr_hstep_t step_sel;
    logic       emit;
    logic       last;
    logic       finish;
  } crr_cmd_t;

  typedef struct packed {
    logic phase_lt_one;
    logic next_ge_one;
    logic out_free;
  } crr_status_t;

endpackage

`default_nettype wire

// File: rtl/core/crr_sample_if.sv
`default_nettype none

interface crr_sample_if import crr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

`default_nettype wire

// File: rtl/core/crr_result_if.sv
`default_nettype none

interface crr_result_if import crr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_re;
  logic signed [SAMPLE_BITS-1:0] out_im;
  logic                          run_last;

  modport source (output valid, output out_re, output out_im, output run_last, input ready);
  modport sink (input valid, input out_re, input out_im, input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/crr_ctrl.sv
`default_nettype none

module crr_ctrl import crr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire crr_status_t status,
  output crr_cmd_t         cmd
);

  crr_state_t            state, state_next;
  crr_hstep_t            step, step_next;
  logic [RUN_BITS-1:0]   run_cnt, run_cnt_next;
  logic                  more;

  assign more = status.phase_lt_one && (run_cnt < RUN_BITS'(MAX_RUN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      step    <= HS_C2;
      run_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      run_cnt <= run_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    run_cnt_next = run_cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next   = ST_CHECK;
          run_cnt_next = '0;
        end
      end
      ST_CHECK: begin
        if (more) begin
          state_next = ST_EVAL;
          step_next  = HS_C2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        case (step)
          HS_C2:   step_next = HS_C1;
          HS_C1:   step_next = HS_C0;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next   = ST_CHECK;
          run_cnt_next = run_cnt + RUN_BITS'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.h_init = more;
        cmd.finish = !more;
      end
      ST_EVAL: begin
        cmd.h_step   = 1'b1;
        cmd.step_sel = step;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        // last word of the run: phase leaves [0,1) or the run cap is hit
        cmd.last = status.next_ge_one || (run_cnt == RUN_BITS'(MAX_RUN - 1));
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/crr_datapath.sv
`default_nettype none

module crr_datapath import crr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire crr_cmd_t                      cmd,
  output crr_status_t                        status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [PHASE_BITS-1:0]         cfg_wr_data,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_re,
  output logic signed [SAMPLE_BITS-1:0]      out_im,
  output logic                               run_last
);

  localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(64'd1 << (PHASE_FRAC_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] hist [NUM_CH][NUM_HIST];
  logic signed [SAMPLE_BITS-1:0] new_smp [NUM_CH];
  logic signed [H_BITS-1:0]      coef3 [NUM_CH];
  logic signed [H_BITS-1:0]      coef2 [NUM_CH];
  logic signed [H_BITS-1:0]      coef1 [NUM_CH];
  logic signed [H_BITS-1:0]      coef0 [NUM_CH];
  logic signed [H_BITS-1:0]      c3_next [NUM_CH];
  logic signed [H_BITS-1:0]      c2_next [NUM_CH];
  logic signed [H_BITS-1:0]      c1_next [NUM_CH];
  logic signed [H_BITS-1:0]      c0_next [NUM_CH];
  logic signed [H_BITS-1:0]      h [NUM_CH];
  logic signed [H_BITS-1:0]      coef_sel [NUM_CH];
  logic signed [PROD_BITS-1:0]   prod [NUM_CH];
  logic signed [PROD_BITS-1:0]   prod_rnd [NUM_CH];
  logic signed [H_BITS-1:0]      h_next [NUM_CH];
  logic signed [H_BITS-1:0]      r_half [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] sat [NUM_CH];

  logic [PHASE_BITS-1:0]         phase;
  logic [PHASE_BITS-1:0]         phase_sum;
  logic [PHASE_BITS-1:0]         ratio;
  logic [PHASE_BITS-1:0]         ratio_next;
  logic signed [PHASE_FRAC_BITS:0] t_s;

  assign new_smp[0] = sample_re;
  assign new_smp[1] = sample_im;

  // window is hist[0..2] plus the new word, oldest first; coefficients are doubled
  always_comb begin
    logic signed [H_BITS-1:0] e0, e1, e2, e3;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e0 = H_BITS'(hist[ch][0]);
      e1 = H_BITS'(hist[ch][1]);
      e2 = H_BITS'(hist[ch][2]);
      e3 = H_BITS'(new_smp[ch]);
      c3_next[ch] = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      c2_next[ch] = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c1_next[ch] = e2 - e0;
      c0_next[ch] = e1 <<< 1;
    end
  end

  assign t_s = signed'({1'b0, phase[PHASE_FRAC_BITS-1:0]});

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case (cmd.step_sel)
        HS_C2:   coef_sel[ch] = coef2[ch];
        HS_C1:   coef_sel[ch] = coef1[ch];
        HS_C0:   coef_sel[ch] = coef0[ch];
        default: coef_sel[ch] = coef0[ch];
      endcase
      prod[ch]     = PROD_BITS'(h[ch]) * PROD_BITS'(t_s);
      // round half up: add half an LSB, then arithmetic shift
      prod_rnd[ch] = (prod[ch] + HALF) >>> PHASE_FRAC_BITS;
      h_next[ch]   = coef_sel[ch] + prod_rnd[ch][H_BITS-1:0];
      r_half[ch]   = (h[ch] + H_BITS'(1)) >>> 1;
      if (r_half[ch] > H_BITS'(SMAX)) begin
        sat[ch] = SAMPLE_BITS'(SMAX);
      end else if (r_half[ch] < H_BITS'(SMIN)) begin
        sat[ch] = SAMPLE_BITS'(SMIN);
      end else begin
        sat[ch] = r_half[ch][SAMPLE_BITS-1:0];
      end
    end
  end

  assign phase_sum = phase + ratio;

  always_comb begin
    if (cfg_wr_data < RATIO_MIN) begin
      ratio_next = RATIO_MIN;
    end else if (cfg_wr_data > RATIO_MAX) begin
      ratio_next = RATIO_MAX;
    end else begin
      ratio_next = cfg_wr_data;
    end
  end

  assign status.phase_lt_one = phase < PH_ONE;
  assign status.next_ge_one  = phase_sum >= PH_ONE;
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int k = 0; k < NUM_HIST; k++) begin
          hist[ch][k] <= '0;
        end
      end
      phase     <= PH_RESET;
      ratio     <= PH_ONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          hist[ch][0] <= hist[ch][1];
          hist[ch][1] <= hist[ch][2];
          hist[ch][2] <= new_smp[ch];
        end
      end
      if (cmd.emit) begin
        phase <= phase_sum;
      end else if (cmd.finish) begin
        // a run cut short by the cap skips the rest of the interval
        phase <= status.phase_lt_one ? '0 : phase - PH_ONE;
      end
      if (cfg_wr_en) begin
        ratio <= ratio_next;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cmd.load) begin
        coef3[ch] <= c3_next[ch];
        coef2[ch] <= c2_next[ch];
        coef1[ch] <= c1_next[ch];
        coef0[ch] <= c0_next[ch];
      end
      if (cmd.h_init) begin
        h[ch] <= coef3[ch];
      end else if (cmd.h_step) begin
        h[ch] <= h_next[ch];
      end
    end
    if (cmd.emit) begin
      out_re   <= sat[0];
      out_im   <= sat[1];
      run_last <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/catmull_rom_fractional_resampler.sv
// An accepted input word is loaded in IDLE; each result from it then passes through CHECK,
// the three Horner EVAL passes through one multiplier per lane, and EMIT, which waits until
// the output register is free; a final CHECK returns to IDLE, where the next word is taken.
// A waiting result in the output register does not block the next input word.
// Reset (rst, synchronous): history zero, phase 2.0, step ratio 1.0; no clearing pass.
`default_nettype none

module catmull_rom_fractional_resampler import crr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  crr_sample_if.sink                 sample_bus,
  crr_result_if.source               result_bus,
  input  wire logic                  cfg_wr_en,
  input  wire logic [PHASE_BITS-1:0] cfg_wr_data
);

  crr_cmd_t    cmd;
  crr_status_t status;
  logic        in_ready;

  assign sample_bus.ready = in_ready;

  crr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_bus.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  crr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample_re   (sample_bus.sample_re),
    .sample_im   (sample_bus.sample_im),
    .out_ready   (result_bus.ready),
    .out_valid   (result_bus.valid),
    .out_re      (result_bus.out_re),
    .out_im      (result_bus.out_im),
    .run_last    (result_bus.run_last)
  );

  // never overwrite a result word the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_bus.valid || result_bus.ready))
    else $error("result word overwritten");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_bus.valid)
    else $error("emitted word not presented");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.h_step || cmd.emit || cmd.h_init))
    else $error("input taken during interpolation");

endmodule

`default_nettype wire
